### rtl/nlp_pkg.sv
// Shared types, codes and constants for the length-prefix to Annex B converter.
package nlp_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEC_HEVC  = 2'd1;
  localparam logic [2:0] LENGTH_SIZE_RST = 3'd4;
  localparam logic [2:0] LENGTH_SIZE_MAX = 3'd4;

  // Parser phase codes
  localparam logic [1:0] PH_PREFIX  = 2'd0;
  localparam logic [1:0] PH_FIRST   = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DRAIN   = 2'd3;

  // Sample status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ZERO_LEN   = 3'd1;
  localparam logic [2:0] ST_TRUNCATED  = 3'd2;
  localparam logic [2:0] ST_PARTIAL    = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  // Key-frame NAL types
  localparam logic [5:0] AVC_IDR_TYPE  = 6'd5;
  localparam logic [5:0] HEVC_IRAP_LO  = 6'd16;
  localparam logic [5:0] HEVC_IRAP_HI  = 6'd21;

  // Start code layout: 00 00 00 01
  localparam logic [2:0] SC_LEN      = 3'd4;
  localparam logic [2:0] SC_LAST_IDX = 3'd3;
  localparam logic [7:0] SC_ZERO     = 8'h00;
  localparam logic [7:0] SC_ONE      = 8'h01;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       sample_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_data;
    logic       nal_first;
    logic [5:0] unit_type;
    logic       sample_end;
    logic       key_pic;
    logic [2:0] status;
    logic       last;
  } out_item_t;

  // Everything one input item produces, expanded into results later
  typedef struct packed {
    logic [7:0] pay_byte;
    logic [5:0] unit_type;
    logic       start_code;
    logic       has_data;
    logic       has_status;
    logic       key_pic;
    logic [2:0] status;
    logic [2:0] count;
  } desc_t;

endpackage

### rtl/nlp_parser.sv
// Sample parser: prefix/payload tracking and per-item result descriptor.
module nlp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [2:0]        length_size_i,
  input  logic              codec_hevc_i,
  input  nlp_pkg::in_item_t item_i,
  input  logic              move_i,
  output nlp_pkg::desc_t    desc_o
);

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  pc_q, pc_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] left_q, left_d;
  logic [5:0]  type_q, type_d;
  logic        key_q, key_d;
  logic        seen_q, seen_d;
  logic [2:0]  err_q, err_d;

  logic [2:0]  lsz;
  logic [31:0] acc_shift;
  logic [31:0] left_dec;
  logic [2:0]  pc_inc;
  logic [5:0]  type_v;
  logic        key_v;
  logic [2:0]  st;
  nlp_pkg::desc_t desc;

  // Next state and descriptor for the item at the input register
  always_comb begin
    lsz = length_size_i;
    if (length_size_i == 3'd0) begin
      lsz = 3'd1;
    end else if (length_size_i > nlp_pkg::LENGTH_SIZE_MAX) begin
      lsz = nlp_pkg::LENGTH_SIZE_MAX;
    end
    acc_shift = {acc_q[23:0], item_i.in_byte};
    left_dec  = left_q - 32'd1;
    pc_inc    = pc_q + 3'd1;
    type_v    = type_q;
    key_v     = 1'b0;
    st        = nlp_pkg::ST_OK;
    phase_d   = phase_q;
    pc_d      = pc_q;
    acc_d     = acc_q;
    left_d    = left_q;
    type_d    = type_q;
    key_d     = key_q;
    seen_d    = seen_q;
    err_d     = err_q;
    desc      = '0;

    case (phase_q)
      nlp_pkg::PH_PREFIX: begin
        acc_d = acc_shift;
        pc_d  = pc_inc;
        if (pc_inc >= lsz) begin
          pc_d = 3'd0;
          if (acc_shift == 32'd0) begin
            err_d   = nlp_pkg::ST_ZERO_LEN;
            phase_d = nlp_pkg::PH_DRAIN;
          end else begin
            left_d  = acc_shift;
            phase_d = nlp_pkg::PH_FIRST;
          end
        end
      end
      nlp_pkg::PH_FIRST, nlp_pkg::PH_PAYLOAD: begin
        if (phase_q == nlp_pkg::PH_FIRST) begin
          // NAL header: type and key-frame check
          if (codec_hevc_i) begin
            type_v = (|acc_q[31:1]) ? item_i.in_byte[6:1] : 6'd0;
            key_v  = (type_v >= nlp_pkg::HEVC_IRAP_LO) && (type_v <= nlp_pkg::HEVC_IRAP_HI);
          end else begin
            type_v = {1'b0, item_i.in_byte[4:0]};
            key_v  = (type_v == nlp_pkg::AVC_IDR_TYPE);
          end
          type_d = type_v;
          if (key_v) begin
            key_d = 1'b1;
          end
          seen_d          = 1'b1;
          desc.start_code = 1'b1;
          phase_d         = nlp_pkg::PH_PAYLOAD;
        end
        desc.has_data  = 1'b1;
        desc.pay_byte  = item_i.in_byte;
        desc.unit_type = type_v;
        left_d         = left_dec;
        if (left_dec == 32'd0) begin
          phase_d = nlp_pkg::PH_PREFIX;
          pc_d    = 3'd0;
          acc_d   = 32'd0;
        end
      end
      default: begin
        // drain after a zero length: bytes are dropped
      end
    endcase

    // Sample end: status from the updated state, then back to reset values
    if (item_i.sample_last) begin
      if (err_d != nlp_pkg::ST_OK) begin
        st = err_d;
      end else if (phase_d == nlp_pkg::PH_FIRST || phase_d == nlp_pkg::PH_PAYLOAD) begin
        st = nlp_pkg::ST_TRUNCATED;
      end else if (pc_d != 3'd0) begin
        st = seen_d ? nlp_pkg::ST_PARTIAL : nlp_pkg::ST_EMPTY;
      end else if (!seen_d) begin
        st = nlp_pkg::ST_EMPTY;
      end else begin
        st = nlp_pkg::ST_OK;
      end
      desc.has_status = 1'b1;
      desc.key_pic    = key_d;
      desc.status     = st;
      phase_d = nlp_pkg::PH_PREFIX;
      pc_d    = 3'd0;
      acc_d   = 32'd0;
      left_d  = 32'd0;
      type_d  = 6'd0;
      key_d   = 1'b0;
      seen_d  = 1'b0;
      err_d   = nlp_pkg::ST_OK;
    end

    desc.count = (desc.start_code ? nlp_pkg::SC_LEN : 3'd0)
               + {2'b00, desc.has_data} + {2'b00, desc.has_status};
  end

  assign desc_o = desc;

  // Sample state, updated as each item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nlp_pkg::PH_PREFIX;
      pc_q    <= 3'd0;
      acc_q   <= 32'd0;
      left_q  <= 32'd0;
      type_q  <= 6'd0;
      key_q   <= 1'b0;
      seen_q  <= 1'b0;
      err_q   <= nlp_pkg::ST_OK;
    end else if (move_i) begin
      phase_q <= phase_d;
      pc_q    <= pc_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      type_q  <= type_d;
      key_q   <= key_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
    end
  end

endmodule

### rtl/nlp_seq.sv
// Result sequencer: holds one descriptor and emits its results one per cycle while out_ready_i is high.
module nlp_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nlp_pkg::desc_t     desc_i,
  input  logic               load_i,
  input  logic               out_ready_i,
  output logic               free_o,
  output logic               out_valid_o,
  output nlp_pkg::out_item_t out_item_o
);

  nlp_pkg::desc_t desc_q;
  logic           valid_q;
  logic [2:0]     cnt_q;
  logic [2:0]     base;
  logic           last;
  nlp_pkg::out_item_t res;

  assign base   = desc_q.start_code ? nlp_pkg::SC_LEN : 3'd0;
  assign last   = (cnt_q == desc_q.count - 3'd1);
  assign free_o = !valid_q || (out_ready_i && last);

  // Pick the result at the current index
  always_comb begin
    res      = '0;
    res.last = last;
    if (cnt_q < base) begin
      res.data_byte = (cnt_q == nlp_pkg::SC_LAST_IDX) ? nlp_pkg::SC_ONE : nlp_pkg::SC_ZERO;
      res.is_data   = 1'b1;
      res.nal_first = (cnt_q == 3'd0);
      res.unit_type = desc_q.unit_type;
    end else if (desc_q.has_data && cnt_q == base) begin
      res.data_byte = desc_q.pay_byte;
      res.is_data   = 1'b1;
      res.unit_type = desc_q.unit_type;
    end else begin
      res.sample_end = 1'b1;
      res.key_pic    = desc_q.key_pic;
      res.status     = desc_q.status;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res;

  // Descriptor register and result index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= 3'd0;
    end else if (free_o) begin
      valid_q <= load_i;
      cnt_q   <= 3'd0;
    end else if (out_ready_i) begin
      cnt_q <= cnt_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o) begin
      desc_q <= desc_i;
    end
  end

endmodule

### rtl/nal_length_prefix_to_annexb_unit.sv
// Top level: length-prefixed NAL samples in, Annex B bytes and sample status out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------
//   in      | input     | in_valid_i/in_ready_o  | in_item_i: sample byte, last flag
//   out     | output    | out_valid_o/out_ready_i| out_item_o: one result
//   cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//
// A prefix byte gives no result, a payload byte after the first gives one, the
// first payload byte of a NAL gives the start code and the byte, and an item
// that ends the sample adds the status result. An accepted item reaches the
// output through the input register and then the sequencer's descriptor
// register. The input register can take one item while the sequencer is still
// sending. Reset clears all control and sample state and loads length_size 4, codec_hevc 0.
module nal_length_prefix_to_annexb_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  nlp_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output nlp_pkg::out_item_t               out_item_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nlp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nlp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic [2:0]        length_size_q;
  logic              codec_hevc_q;
  nlp_pkg::in_item_t inq_q;
  logic              inq_valid_q;
  logic              seq_free;
  logic              move;
  nlp_pkg::desc_t    desc;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_size_q <= nlp_pkg::LENGTH_SIZE_RST;
      codec_hevc_q  <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == nlp_pkg::CFG_LENGTH_SIZE) begin
        length_size_q <= cfg_data_i;
      end else if (cfg_index_i == nlp_pkg::CFG_CODEC_HEVC) begin
        codec_hevc_q <= cfg_data_i[0];
      end
    end
  end

  // Input register: item moves on when the sequencer can take its results
  assign move       = inq_valid_q && seq_free;
  assign in_ready_o = !inq_valid_q || seq_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      inq_q <= in_item_i;
    end
  end

  nlp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .length_size_i (length_size_q),
    .codec_hevc_i  (codec_hevc_q),
    .item_i        (inq_q),
    .move_i        (move),
    .desc_o        (desc)
  );

  nlp_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .desc_i      (desc),
    .load_i      (move && (desc.count != 3'd0)),
    .out_ready_i (out_ready_i),
    .free_o      (seq_free),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // The status result always closes the item's results
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.sample_end |-> out_item_o.last)
    else $error("status result not marked last");

  // A NAL opens with a zero start-code byte
  a_first_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.nal_first |->
      out_item_o.is_data && out_item_o.data_byte == nlp_pkg::SC_ZERO)
    else $error("NAL start not a start-code zero byte");

  // Results of one item follow without a gap
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !out_item_o.last |=> out_valid_o)
    else $error("result sequence broken before last");
`endif

endmodule
